/* design/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/les_pkg.sv */
// shared widths, operation codes and status codes of the line edit buffer
`timescale 1ns / 1ps
`default_nettype none

package les_pkg;

    localparam int FUNC_W = 3;
    localparam int IDX_W  = 8;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 9;
    localparam int STAT_W = 2;

    localparam int MAX_LEN_DEFAULT = 256;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

/* design/les_mem.sv */
// character store: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module les_mem
    import les_pkg::*;
#(
    parameter int DEPTH = MAX_LEN_DEFAULT,
    parameter int AW    = $clog2(MAX_LEN_DEFAULT)
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [CHAR_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [CHAR_W-1:0] wr_data
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/les_ctrl.sv */
// operation sequencer: range checks, tail shifting through the store, result register
`timescale 1ns / 1ps
`default_nettype none

module les_ctrl
    import les_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT,
    parameter int AW      = $clog2(MAX_LEN_DEFAULT),
    parameter int CNT_W   = $clog2(MAX_LEN_DEFAULT + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [FUNC_W-1:0] func,
    input  wire logic [IDX_W-1:0]  index,
    input  wire logic [CHAR_W-1:0] char_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [CHAR_W-1:0] char_out,
    output logic      [LEN_W-1:0]  line_length,
    output logic      [STAT_W-1:0] status,
    output logic                   rd_en,
    output logic      [AW-1:0]     rd_addr,
    input  wire logic [CHAR_W-1:0] rd_data,
    output logic                   wr_en,
    output logic      [AW-1:0]     wr_addr,
    output logic      [CHAR_W-1:0] wr_data
);

    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [CHAR_W-1:0] res_char_reg, res_char_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [STAT_W-1:0] out_stat_reg, out_stat_next;

    logic [CMP_W-1:0]  idx_w;
    logic [CMP_W-1:0]  cnt_w;
    logic [CNT_W-1:0]  cur_inc;
    logic [CNT_W-1:0]  cur_dec;
    logic              is_full;

    assign idx_w   = CMP_W'(index);
    assign cnt_w   = CMP_W'(count_reg);
    assign cur_inc = cur_reg + CNT_W'(1);
    assign cur_dec = cur_reg - CNT_W'(1);
    assign is_full = (count_reg == CNT_W'(MAX_LEN));

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        res_char_next  = res_char_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_len_next   = out_len_reg;
        out_stat_next  = out_stat_reg;
        rd_en          = 1'b0;
        rd_addr        = AW'(index);
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_char_next = '0;
                    res_stat_next = ST_OK;
                    state_next    = S_FIN;
                    pend_next     = 1'b0;
                    ch_next       = char_in;
                    case (func)
                        FN_READ:
                        begin
                            if (idx_w < cnt_w)
                            begin
                                rd_en      = 1'b1;
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                res_stat_next = ST_RANGE;
                            end
                        end
                        FN_INSERT:
                        begin
                            if (idx_w > cnt_w)
                            begin
                                res_stat_next = ST_RANGE;
                            end
                            else if (is_full)
                            begin
                                res_stat_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next   = CNT_W'(index);
                                cur_next   = count_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        FN_APPEND:
                        begin
                            if (is_full)
                            begin
                                res_stat_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next   = count_reg;
                                cur_next   = count_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        FN_DELETE:
                        begin
                            if (idx_w >= cnt_w)
                            begin
                                res_stat_next = ST_RANGE;
                            end
                            else
                            begin
                                pos_next   = CNT_W'(index);
                                cur_next   = CNT_W'(index);
                                state_next = S_SHIFT_DN;
                            end
                        end
                        FN_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                res_char_next = rd_data;
                state_next    = S_FIN;
            end
            S_SHIFT_UP:
            begin
                // write back the entry read last cycle, one slot higher
                if (pend_reg)
                begin
                    wr_en = 1'b1;
                end
                if (cur_reg > pos_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = AW'(cur_dec);
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(cur_reg);
                    cur_next       = cur_dec;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(pos_reg);
                        wr_data    = ch_reg;
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_FIN;
                    end
                end
            end
            S_SHIFT_DN:
            begin
                // write back the entry read last cycle, one slot lower
                if (pend_reg)
                begin
                    wr_en = 1'b1;
                end
                if (cur_inc < count_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = AW'(cur_inc);
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(cur_reg);
                    cur_next       = cur_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = res_char_reg;
                    out_len_next   = LEN_W'(count_reg);
                    out_stat_next  = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            pos_reg       <= '0;
            ch_reg        <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            res_char_reg  <= '0;
            res_stat_reg  <= ST_OK;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_len_reg   <= '0;
            out_stat_reg  <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            pos_reg       <= pos_next;
            ch_reg        <= ch_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            res_char_reg  <= res_char_next;
            res_stat_reg  <= res_stat_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_len_reg   <= out_len_next;
            out_stat_reg  <= out_stat_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = out_char_reg;
    assign line_length = out_len_reg;
    assign status      = out_stat_reg;

endmodule

`default_nettype wire

/* design/line_edit_buffer.sv */
// top level of the line edit buffer: sequencer plus character store
//
// usage
// - input channel (in_valid/in_ready) carries func, index and char_in; one
//   transfer asks for read, insert, delete, append or clear
// - output channel (out_valid/out_ready) carries char_out, line_length and
//   status; every input transfer yields exactly one output transfer, in order
// - one item is worked on at a time; in_ready is high only while the
//   sequencer is idle, and rises again in the cycle out_valid is loaded
// - clear, refused and out-of-range items go straight to the output register;
//   a read first waits for the registered read data of the store; an insert or
//   a delete first moves the tail of the line, unless nothing lies behind it;
//   the tail moves one entry per cycle, read-to-write pipelined
// - worst case is an insert at index 0 with MAX_LEN-1 characters held, or a delete at index 0 with MAX_LEN held
// - the result sits in an output register; a new item can be taken while it
//   waits, and a finished result is held back until the register drains
// - reset clears the length to zero and empties the output register; the
//   store is not cleared, only entries below the length are ever read
// - a stalled receiver simply holds the result; nothing is lost
`timescale 1ns / 1ps
`default_nettype none

module line_edit_buffer
    import les_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [FUNC_W-1:0] func,
    input  wire logic [IDX_W-1:0]  index,
    input  wire logic [CHAR_W-1:0] char_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [CHAR_W-1:0] char_out,
    output logic      [LEN_W-1:0]  line_length,
    output logic      [STAT_W-1:0] status
);

    // store address and length counter widths follow the capacity
    localparam int AW    = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    // store port between sequencer and memory
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CHAR_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CHAR_W-1:0] wr_data;

    // sequencer: checks, shifting and the result register
    les_ctrl #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .index       (index),
        .char_in     (char_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_out    (char_out),
        .line_length (line_length),
        .status      (status),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    // character store with registered read data
    les_mem #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire

/* design/les_checker.sv */
// port-level checker for the line edit buffer and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module les_checker
    import les_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic [FUNC_W-1:0] func,
    input  wire logic [IDX_W-1:0]  index,
    input  wire logic [CHAR_W-1:0] char_in,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic [CHAR_W-1:0] char_out,
    input  wire logic [LEN_W-1:0]  line_length,
    input  wire logic [STAT_W-1:0] status
);

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_LEN);

    logic [FUNC_W+IDX_W+CHAR_W-1:0]  req_bits;
    logic [CHAR_W+LEN_W+STAT_W-1:0]  res_bits;
    logic                            in_wait;
    logic                            out_wait;
    logic                            char_seen;
    logic                            read_ok;

    assign req_bits  = {func, index, char_in};
    assign res_bits  = {char_out, line_length, status};
    assign in_wait   = in_valid && !in_ready;
    assign out_wait  = out_valid && !out_ready;
    assign char_seen = out_valid && (char_out != '0);
    assign read_ok   = (status == ST_OK) && (line_length != '0);

    `LES_ASSERT_NXT(a_in_hold, in_wait, in_valid && $stable(req_bits), "request not held")
    `LES_ASSERT_NXT(a_out_hold, out_wait, out_valid && $stable(res_bits), "result not held")
    `LES_ASSERT_IMP(a_status_code, out_valid, status <= ST_FULL, "undefined status code")
    `LES_ASSERT_IMP(a_full_len, out_valid && status == ST_FULL, line_length == FULL_LEN, "full refusal")
    `LES_ASSERT_IMP(a_char_ok, char_seen, read_ok, "character on failed read")
    `LES_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

endmodule

bind line_edit_buffer les_checker #(.MAX_LEN(MAX_LEN)) u_les_checker (.*);

`default_nettype wire
